// ===== sv/checked_date_difference_macros.svh =====
// ----------------------------------------------------------------------------
// Checked date difference: assertion macros
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHECKED_DATE_DIFFERENCE_MACROS_SVH
`define CHECKED_DATE_DIFFERENCE_MACROS_SVH

// Plain property on the block clock
`define CHKDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication
`define CHKDD_ASSERT_IMP(label, ante, cons, msg) \
  `CHKDD_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define CHKDD_ASSERT_NXT(label, ante, cons, msg) \
  `CHKDD_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== sv/chkdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked date difference package
// Word types, status codes, register map and the month offset table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chkdd_pkg;

  // Field widths
  localparam int unsigned DAY_W  = 6;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 12;
  localparam int unsigned KEY_W  = YEAR_W + MON_W + DAY_W;
  localparam int unsigned YOFF_W = YEAR_W + 1;   // signed year offset from 1900
  localparam int unsigned MOFF_W = 9;            // month offset, up to 367
  localparam int unsigned DN_W   = 22;           // signed day number
  localparam int unsigned DELTA_W = DN_W + 1;    // signed day number difference
  localparam int unsigned DIFF_W = 18;

  // Day number constants
  localparam logic [YOFF_W-1:0] BASE_YEAR = YOFF_W'(1900);
  localparam logic [DN_W-1:0]   DAYS_YEAR = DN_W'(365);
  localparam logic [DN_W-1:0]   DN_BIAS   = DN_W'(58);

  // x / 100 as (x * 5243) >> 19, exact for 12-bit x
  localparam int unsigned RCP_W     = 13;
  localparam int unsigned PROD_W    = YEAR_W + RCP_W;
  localparam int unsigned RCP_SHIFT = 19;
  localparam int unsigned CENT_W    = PROD_W - RCP_SHIFT;
  localparam logic [RCP_W-1:0] RCP_100 = RCP_W'(5243);

  // APB register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_EARLIEST = 1'b0;
  localparam logic REG_LATEST   = 1'b1;
  localparam logic [YEAR_W-1:0] EARLIEST_RST = YEAR_W'(1900);
  localparam logic [YEAR_W-1:0] LATEST_RST   = YEAR_W'(2300);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_START_BAD = 2'd1,
    ST_END_BAD   = 2'd2,
    ST_ORDER     = 2'd3
  } status_e;

  typedef struct packed {
    logic [DAY_W-1:0]  from_day;
    logic [MON_W-1:0]  from_month;
    logic [YEAR_W-1:0] from_year;
    logic [DAY_W-1:0]  to_day;
    logic [MON_W-1:0]  to_month;
    logic [YEAR_W-1:0] to_year;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [DIFF_W-1:0] day_difference;
  } out_word_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  // Stage load enables for a lane
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

  // What a lane hands to the merge stage
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;   // {year, month, day} for ordering
    logic [DN_W-1:0]  dn;    // two's complement day number
  } lane_res_t;

  // (153*m + 2) / 5 with m = month + 12*a - 3, a = (14 - month) / 12
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MON_W-1:0] mon);
    logic [MOFF_W-1:0] off;
    case (mon)
      4'd0:    off = MOFF_W'(275);
      4'd1:    off = MOFF_W'(306);
      4'd2:    off = MOFF_W'(337);
      4'd3:    off = MOFF_W'(0);
      4'd4:    off = MOFF_W'(31);
      4'd5:    off = MOFF_W'(61);
      4'd6:    off = MOFF_W'(92);
      4'd7:    off = MOFF_W'(122);
      4'd8:    off = MOFF_W'(153);
      4'd9:    off = MOFF_W'(184);
      4'd10:   off = MOFF_W'(214);
      4'd11:   off = MOFF_W'(245);
      4'd12:   off = MOFF_W'(275);
      4'd13:   off = MOFF_W'(306);
      4'd14:   off = MOFF_W'(337);
      default: off = MOFF_W'(367);
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== sv/chkdd_lane.sv =====
// ----------------------------------------------------------------------------
// Date lane
// Validates one date and computes its day number over two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chkdd_lane
  import chkdd_pkg::*;
(
  input  logic              clk_i,
  input  pipe_en_t          en_i,
  input  date_t             date_i,
  input  logic [YEAR_W-1:0] earliest_i,
  input  logic [YEAR_W-1:0] latest_i,
  output lane_res_t         res_o
);

  // ---- stage 1: validation and year offset ----
  logic [PROD_W-1:0] cent_prod;
  logic [CENT_W-1:0] cent;
  logic [YEAR_W-1:0] rem100;
  logic              leap;
  logic              range_ok, month_ok, day_ok, fit_ok, thirty;
  logic              early_mon;
  logic [YOFF_W-1:0] yoff;

  assign cent_prod = PROD_W'(date_i.year) * PROD_W'(RCP_100);
  assign cent      = cent_prod[PROD_W-1:RCP_SHIFT];
  assign rem100    = date_i.year - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
  // divisible by 4, and not by 100 unless by 400
  assign leap      = (date_i.year[1:0] == 2'b00) &&
                     ((rem100 != '0) || (cent[1:0] == 2'b00));

  always_comb begin
    range_ok = (date_i.year >= earliest_i) && (date_i.year <= latest_i);
    month_ok = (date_i.month >= MON_W'(1)) && (date_i.month <= MON_W'(12));
    day_ok   = (date_i.day >= DAY_W'(1)) && (date_i.day <= DAY_W'(31));
    thirty   = date_i.month inside {MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11)};
    fit_ok   = 1'b1;
    if (date_i.month == MON_W'(2)) begin
      if (date_i.day > DAY_W'(29)) fit_ok = 1'b0;
      if (!leap && (date_i.day > DAY_W'(28))) fit_ok = 1'b0;
    end
    if (thirty && (date_i.day > DAY_W'(30))) fit_ok = 1'b0;
  end

  // January and February count as months of the previous year
  assign early_mon = (date_i.month <= MON_W'(2));
  assign yoff      = {1'b0, date_i.year} - BASE_YEAR - YOFF_W'(early_mon);

  logic              s1_ok_q;
  logic [YOFF_W-1:0] s1_yoff_q;
  logic [MOFF_W-1:0] s1_moff_q;
  logic [DAY_W-1:0]  s1_day_q;
  logic [KEY_W-1:0]  s1_key_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_ok_q   <= range_ok && month_ok && day_ok && fit_ok;
      s1_yoff_q <= yoff;
      s1_moff_q <= month_offset(date_i.month);
      s1_day_q  <= date_i.day;
      s1_key_q  <= {date_i.year, date_i.month, date_i.day};
    end
  end

  // ---- stage 2: day number ----
  // Truncating division of a negative offset is minus the quotient of its magnitude.
  logic              neg;
  logic [YEAR_W-1:0] ymag;
  logic [PROD_W-1:0] ycent_prod;
  logic [CENT_W-1:0] ycent;
  logic [YEAR_W-1:0] corr;
  logic [DN_W-1:0]   yext, corr_s, dn;

  assign neg        = s1_yoff_q[YOFF_W-1];
  assign ymag       = neg ? YEAR_W'(-s1_yoff_q) : s1_yoff_q[YEAR_W-1:0];
  assign ycent_prod = PROD_W'(ymag) * PROD_W'(RCP_100);
  assign ycent      = ycent_prod[PROD_W-1:RCP_SHIFT];
  // y/4 - y/100 + y/400 on the magnitude
  assign corr       = (ymag >> 2) - YEAR_W'(ycent) + YEAR_W'(ycent >> 2);
  assign corr_s     = neg ? -DN_W'(corr) : DN_W'(corr);
  assign yext       = {{(DN_W-YOFF_W){s1_yoff_q[YOFF_W-1]}}, s1_yoff_q};
  assign dn         = yext * DAYS_YEAR + corr_s + DN_W'(s1_day_q) +
                      DN_W'(s1_moff_q) + DN_BIAS;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      res_o.ok  <= s1_ok_q;
      res_o.key <= s1_key_q;
      res_o.dn  <= dn;
    end
  end

endmodule

`default_nettype wire

// ===== sv/chkdd_merge.sv =====
// ----------------------------------------------------------------------------
// Lane merge and output register
// Picks the status, subtracts the day numbers and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chkdd_merge
  import chkdd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  lane_res_t start_i,
  input  lane_res_t end_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [DELTA_W-1:0] delta;
  out_word_t          word_d, word_q;
  logic               valid_d, valid_q;

  // Difference with clamping to the field range
  assign delta = {end_i.dn[DN_W-1], end_i.dn} - {start_i.dn[DN_W-1], start_i.dn};

  always_comb begin
    word_d.status         = ST_OK;
    word_d.day_difference = '0;
    if (!start_i.ok) begin
      word_d.status = ST_START_BAD;
    end else if (!end_i.ok) begin
      word_d.status = ST_END_BAD;
    end else if (end_i.key < start_i.key) begin
      word_d.status = ST_ORDER;
    end else if (delta[DELTA_W-1]) begin
      word_d.day_difference = '0;
    end else if (delta[DELTA_W-2:DIFF_W] != '0) begin
      word_d.day_difference = '1;
    end else begin
      word_d.day_difference = delta[DIFF_W-1:0];
    end
  end

  // Output slot frees when empty or taken
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== sv/checked_date_difference.sv =====
// ----------------------------------------------------------------------------
// Checked date difference
// Validates a start and an end date and returns the days between them.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with an in_word_t word holding both
// dates. Output channel: out_valid_o / out_stall_i with an out_word_t word
// holding the status and the day difference (zero unless status is ok).
// Both dates go through identical lanes side by side; the merge stage picks
// the status and subtracts the day numbers.
// The edge that takes an input word loads lane stage 1; lane stage 2 and
// the output register follow in turn. Throughput: one word per cycle while the
// receiver does not stall, set by the three-stage pipeline with no loop back.
// When the receiver stalls, the output word holds and the pipeline keeps
// taking words until all three stages are full; only then in_stall_o rises.
// Reset clears all pipeline valids and sets the year range to 1900..2300.
// Year range registers sit on the APB port: earliest_year at 0x0, latest_year
// at 0x4 (paddr[2] selects). Write them only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module checked_date_difference
  import chkdd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---- year range registers ----
  logic [YEAR_W-1:0] earliest_q, earliest_d, latest_q, latest_d;
  logic              cfg_wr;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    earliest_d = earliest_q;
    latest_d   = latest_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_EARLIEST: earliest_d = pwdata[YEAR_W-1:0];
        REG_LATEST:   latest_d   = pwdata[YEAR_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EARLIEST: prdata = APB_DW'(earliest_q);
      REG_LATEST:   prdata = APB_DW'(latest_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      earliest_q <= EARLIEST_RST;
      latest_q   <= LATEST_RST;
    end else begin
      earliest_q <= earliest_d;
      latest_q   <= latest_d;
    end
  end

  // ---- pipeline flow control ----
  logic     s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;
  logic     s1_ready, s2_ready, out_ready;
  logic     in_take;
  pipe_en_t lane_en;

  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_take    = in_valid_i && s1_ready;

  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  assign lane_en.s1 = in_take;
  assign lane_en.s2 = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // ---- date lanes ----
  date_t     start_date, end_date;
  lane_res_t start_res, end_res;

  assign start_date = '{day: in_word_i.from_day, month: in_word_i.from_month,
                        year: in_word_i.from_year};
  assign end_date   = '{day: in_word_i.to_day, month: in_word_i.to_month,
                        year: in_word_i.to_year};

  chkdd_lane u_lane_start (
    .clk_i      (clk_i),
    .en_i       (lane_en),
    .date_i     (start_date),
    .earliest_i (earliest_q),
    .latest_i   (latest_q),
    .res_o      (start_res)
  );

  chkdd_lane u_lane_end (
    .clk_i      (clk_i),
    .en_i       (lane_en),
    .date_i     (end_date),
    .earliest_i (earliest_q),
    .latest_i   (latest_q),
    .res_o      (end_res)
  );

  // ---- merge and output register ----
  chkdd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid_q),
    .start_i     (start_res),
    .end_i       (end_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== sv/chkdd_checker.sv =====
// ----------------------------------------------------------------------------
// Checked date difference port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "checked_date_difference_macros.svh"

module chkdd_checker
  import chkdd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire out_word_t         out_word_o
);

  // a stalled result word stays valid and unchanged
  `CHKDD_ASSERT_NXT(a_hold_valid, out_valid_o && out_stall_i, out_valid_o, "dropped stalled word")
  `CHKDD_ASSERT_NXT(a_hold_word, out_valid_o && out_stall_i, $stable(out_word_o), "stalled word changed")

  // a failed check never carries a day count
  `CHKDD_ASSERT_IMP(a_diff_zero, out_valid_o && (out_word_o.status != ST_OK), out_word_o.day_difference == '0, "difference on failed check")

  // input back-pressure only comes from a blocked output
  `CHKDD_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled with free output")

endmodule

bind checked_date_difference chkdd_checker u_chkdd_checker (.*);

`default_nettype wire

// ===== bench/tb_checked_date_difference.sv =====
// ----------------------------------------------------------------------------
// Checked date difference testbench
// Drives date pairs through the block under several year ranges, with
// sender gaps and receiver stalls. An in-bench predictor computes the
// expected status and day count for every accepted word. A scoreboard
// compares each result word against those predictions in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checked_date_difference;
  import chkdd_pkg::*;

  localparam longint SpanCap = (longint'(1) << DIFF_W) - 1;

  // Prediction and in-order comparison of result words
  class date_span_board;
    int unsigned earliest_yr = 1900;
    int unsigned latest_yr   = 2300;
    int unsigned mismatches  = 0;
    out_word_t   expected_spans[$];

    function void flag(string what, longint expv, longint actv);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, expv, actv);
    endfunction

    function void set_year(logic idx, int unsigned value);
      if (idx == REG_EARLIEST) earliest_yr = value;
      else latest_yr = value;
    endfunction

    function bit leap_year(int yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function bit date_valid(int d, int mo, int yr);
      if (yr < int'(earliest_yr) || yr > int'(latest_yr)) return 1'b0;
      if (mo < 1 || mo > 12) return 1'b0;
      if (d < 1 || d > 31) return 1'b0;
      if (mo == 2 && d > (leap_year(yr) ? 29 : 28)) return 1'b0;
      if ((mo == 4 || mo == 6 || mo == 9 || mo == 11) && d > 30) return 1'b0;
      return 1'b1;
    endfunction

    // March-based day index from 1900, truncating division throughout
    function longint day_index(int d, int mo, int yr);
      longint a, y, m;
      a = (14 - longint'(mo)) / 12;
      y = longint'(yr) - 1900 - a;
      m = longint'(mo) + 12 * a - 3;
      return longint'(d) + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 + 58;
    endfunction

    function out_word_t predict_span(in_word_t w);
      out_word_t r;
      longint delta;
      r.status = ST_OK;
      r.day_difference = '0;
      if (!date_valid(w.from_day, w.from_month, w.from_year)) begin
        r.status = ST_START_BAD;
      end else if (!date_valid(w.to_day, w.to_month, w.to_year)) begin
        r.status = ST_END_BAD;
      end else if ({w.to_year, w.to_month, w.to_day} <
                   {w.from_year, w.from_month, w.from_day}) begin
        r.status = ST_ORDER;
      end else begin
        delta = day_index(w.to_day, w.to_month, w.to_year) -
                day_index(w.from_day, w.from_month, w.from_year);
        if (delta < 0) delta = 0;
        if (delta > SpanCap) delta = SpanCap;
        r.day_difference = delta[DIFF_W-1:0];
      end
      return r;
    endfunction

    function void note_dates(in_word_t w);
      expected_spans.push_back(predict_span(w));
    endfunction

    function void check_span(out_word_t got);
      out_word_t want;
      if (expected_spans.size() == 0) begin
        flag("unexpected word", -1, got);
        return;
      end
      want = expected_spans.pop_front();
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.day_difference !== want.day_difference)
        flag("day_difference", want.day_difference, got.day_difference);
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_word_t          in_word_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_word_t         out_word_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  date_span_board sb;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  checked_date_difference i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stall: one of four random patterns, chosen anew when a random countdown runs out
  always @(posedge clk_i) begin
    if (stall_tick == 0) begin
      stall_mode <= $urandom_range(3);
      stall_tick <= $urandom_range(80, 20);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(3) == 0);
      2: out_stall_i <= ($urandom_range(3) != 0);
      default: out_stall_i <= (stall_tick % 3 == 0);
    endcase
  end

  // Handshake monitor; values sampled are those before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_dates(in_word_i);
      if (out_valid_o && !out_stall_i) sb.check_span(out_word_o);
    end
  end

  function automatic in_word_t pair(int sd, int sm, int sy, int ed, int em, int ey);
    date_t s, e;
    s.day = DAY_W'(sd); s.month = MON_W'(sm); s.year = YEAR_W'(sy);
    e.day = DAY_W'(ed); e.month = MON_W'(em); e.year = YEAR_W'(ey);
    return {s, e};
  endfunction

  // Mostly well-formed pairs in range, some with one broken field, some noise
  function automatic in_word_t random_dates(int unsigned lo, int unsigned hi);
    logic [$bits(in_word_t)-1:0] raw;
    logic [63:0] noise;
    int unsigned pick, tmp;
    date_t s, e, t;
    noise = {$urandom, $urandom};
    raw = noise[$bits(in_word_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 15) return raw;
    if (lo > hi) begin
      tmp = lo; lo = hi; hi = tmp;
    end
    s.year = YEAR_W'($urandom_range(hi, lo));
    s.month = MON_W'($urandom_range(12, 1));
    s.day = DAY_W'($urandom_range(31, 1));
    e.year = YEAR_W'($urandom_range(hi, lo));
    e.month = MON_W'($urandom_range(12, 1));
    e.day = DAY_W'($urandom_range(31, 1));
    if (pick >= 30 && pick < 45) begin
      e = s;
      e.day = DAY_W'($urandom_range(31, 1));
    end
    if ({e.year, e.month, e.day} < {s.year, s.month, s.day} && $urandom_range(9) != 0) begin
      t = s; s = e; e = t;
    end
    if (pick < 30) begin
      case ($urandom_range(5))
        0: s.day = DAY_W'($urandom_range(63));
        1: s.month = MON_W'($urandom_range(15));
        2: s.year = YEAR_W'($urandom_range(4095));
        3: e.day = DAY_W'($urandom_range(63));
        4: e.month = MON_W'($urandom_range(15));
        default: e.year = YEAR_W'($urandom_range(4095));
      endcase
    end
    return {s, e};
  endfunction

  // One word to the block; bursts of random length with random gaps
  task automatic send_dates(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        in_word_i <= random_dates(0, 4095);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    repeat (count) send_dates(random_dates(sb.earliest_yr, sb.latest_yr));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // APB write, then read back in the following transfer
  task automatic write_year_reg(logic idx, logic [YEAR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_year(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DW'(value)) sb.flag("register readback", value, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_year_range(int unsigned lo, int unsigned hi);
    drain_results();
    write_year_reg(REG_EARLIEST, YEAR_W'(lo));
    write_year_reg(REG_LATEST, YEAR_W'(hi));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset range 1900..2300: field extremes, month lengths, ordering
    send_dates(pair(29, 2, 2000, 29, 2, 2000));
    send_dates(pair(1, 1, 1900, 31, 12, 2300));
    send_dates(pair(1, 3, 1900, 28, 2, 1901));
    send_dates(pair(1, 1, 1899, 1, 1, 2000));
    send_dates(pair(1, 1, 1899, 0, 0, 0));
    send_dates(pair(1, 0, 2000, 1, 1, 2001));
    send_dates(pair(1, 13, 2000, 1, 1, 2001));
    send_dates(pair(1, 15, 2000, 1, 1, 2001));
    send_dates(pair(0, 5, 2000, 1, 6, 2000));
    send_dates(pair(32, 1, 2000, 1, 6, 2000));
    send_dates(pair(63, 15, 4095, 63, 15, 4095));
    send_dates(pair(0, 0, 0, 0, 0, 0));
    send_dates(pair(29, 2, 1900, 1, 3, 1900));
    send_dates(pair(29, 2, 2100, 1, 3, 2100));
    send_dates(pair(29, 2, 2004, 1, 3, 2004));
    send_dates(pair(30, 2, 2000, 1, 3, 2000));
    send_dates(pair(31, 4, 2001, 1, 5, 2001));
    send_dates(pair(30, 6, 2001, 31, 7, 2001));
    send_dates(pair(1, 1, 2000, 31, 9, 2000));
    send_dates(pair(1, 1, 2000, 1, 1, 2301));
    send_dates(pair(1, 1, 2000, 1, 1, 1999));
    send_dates(pair(15, 6, 2000, 15, 5, 2000));
    send_dates(pair(15, 6, 2000, 14, 6, 2000));
    send_dates(pair(31, 12, 2299, 1, 1, 2300));
    send_random(250);

    // Widest range: years below 1900 and a saturated span
    set_year_range(0, 4095);
    send_dates(pair(1, 1, 0, 31, 12, 4095));
    send_dates(pair(1, 1, 0, 1, 3, 0));
    send_dates(pair(29, 2, 0, 29, 2, 4));
    send_dates(pair(1, 1, 1, 1, 1, 1899));
    send_random(200);

    // Single valid year
    set_year_range(2000, 2000);
    send_random(100);

    // Empty range: nothing is valid
    set_year_range(2300, 1900);
    send_random(50);

    set_year_range(1900, 2300);
    send_random(250);

    drain_results();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/chkdd_pkg.sv
sv/chkdd_lane.sv
sv/chkdd_merge.sv
sv/checked_date_difference.sv
sv/chkdd_checker.sv
bench/tb_checked_date_difference.sv
